### rtl/urlud_pkg.sv
// shared types, codes and defaults for the unit reservation dispatch block
`default_nettype none
package urlud_pkg;

	localparam int DEF_MAX_UNITS   = 64;
	localparam int DEF_MAX_CLIENTS = 16;
	localparam int DEF_USAGE_BITS  = 32;
	localparam int REF_BITS        = 5;
	localparam logic [REF_BITS-1:0] REF_MAX = '1;

	typedef enum logic [1:0] {
		REQ_RESERVE  = 2'd0,
		REQ_RELEASE  = 2'd1,
		REQ_OPEN     = 2'd2,
		REQ_DISPATCH = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NO_UNIT = 3'd1,
		ST_ADDED   = 3'd2,
		ST_EXCL    = 3'd3,
		ST_SHARED  = 3'd4,
		ST_NOT_RES = 3'd5,
		ST_WIDE    = 3'd6,
		ST_NONE    = 3'd7
	} status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_SCAN
	} fsm_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  client_id;
		logic [5:0]  unit_index;
		logic        exclusive;
		logic [63:0] unit_mask;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] chosen_unit;
	} result_t;

	// per-unit update command broadcast to the cell row
	typedef struct packed {
		logic       rsv;
		logic       rsv_excl;
		logic       rel;
		logic       use_inc;
		logic [5:0] idx;
	} unit_cmd_t;

endpackage
`default_nettype wire

### rtl/urlud_cell.sv
// one unit cell: reservation state, usage counter and one step of the min scan
`default_nettype none
module urlud_cell #(
	parameter int INDEX      = 0,
	parameter int UW         = 6,
	parameter int USAGE_BITS = urlud_pkg::DEF_USAGE_BITS
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  urlud_pkg::unit_cmd_t           cmd,
	input  wire                            cand,
	input  wire                            mbit,
	input  wire                            tok_in,
	input  wire                            fnd_in,
	input  wire [USAGE_BITS-1:0]           use_in,
	input  wire [UW-1:0]                   idx_in,
	input  wire [6:0]                      cnt_in,
	output logic                           tok_out,
	output logic                           fnd_out,
	output logic [USAGE_BITS-1:0]          use_out,
	output logic [UW-1:0]                  idx_out,
	output logic [6:0]                     cnt_out,
	output logic [urlud_pkg::REF_BITS-1:0] refcnt,
	output logic                           excl
);
	import urlud_pkg::*;

	logic [REF_BITS-1:0]   ref_q;
	logic                  excl_q;
	logic [USAGE_BITS-1:0] use_q;
	logic                  hit;
	logic                  take;

	assign hit  = (cmd.idx == 6'(INDEX));
	assign take = cand && (!fnd_in || (use_q < use_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q  <= '0;
			excl_q <= 1'b0;
			use_q  <= '0;
		end else if (hit) begin
			if (cmd.rsv) begin
				if (cmd.rsv_excl) begin
					excl_q <= 1'b1;
				end else if (ref_q != REF_MAX) begin
					ref_q <= ref_q + 1'b1;
				end
			end
			if (cmd.rel) begin
				if (excl_q) begin
					excl_q <= 1'b0;
					ref_q  <= '0;
				end else if (ref_q != '0) begin
					ref_q <= ref_q - 1'b1;
				end
			end
			if (cmd.use_inc && !(&use_q)) begin
				use_q <= use_q + 1'b1;
			end
		end
	end

	// scan carry moves one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= 1'b0;
		end else begin
			tok_out <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		cnt_out <= cnt_in + 7'(mbit);
		if (take) begin
			fnd_out <= 1'b1;
			use_out <= use_q;
			idx_out <= UW'(INDEX);
		end else begin
			fnd_out <= fnd_in;
			use_out <= use_in;
			idx_out <= idx_in;
		end
	end

	assign refcnt = ref_q;
	assign excl   = excl_q;

endmodule
`default_nettype wire

### rtl/unit_reservation_least_used_dispatch.sv
// top level: request decode, client holdings and the row of unit cells
// Reserve, release and open requests strobe their result on done in the cycle
// after start and busy never rises, so one may follow every cycle. A dispatch
// raises busy while a scan token walks the row of MAX_UNITS unit cells, one
// cell per cycle, each comparing its usage count against the running minimum
// and adding its mask bit to the running count; done follows from a register
// once the token has left the last cell.
// The winner's usage count is bumped as the token leaves the last cell.
// Results are shown on done for a single cycle and cannot be held off.
// Configuration (active_units) may be written only while no request is open.
`default_nettype none
module unit_reservation_least_used_dispatch #(
	parameter int MAX_UNITS   = urlud_pkg::DEF_MAX_UNITS,
	parameter int MAX_CLIENTS = urlud_pkg::DEF_MAX_CLIENTS,
	parameter int USAGE_BITS  = urlud_pkg::DEF_USAGE_BITS
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  urlud_pkg::req_t    req,
	input  wire                cfg_we,
	input  wire [6:0]          cfg_wdata,
	output logic               done,
	output urlud_pkg::result_t result
);
	import urlud_pkg::*;

	localparam int UW  = $clog2(MAX_UNITS);
	localparam int CLW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

	// configuration and control
	logic [6:0]           active_q;
	logic [6:0]           eff;
	fsm_t                 state_q, state_d;
	logic                 accept;
	logic                 launch_q;
	logic [63:0]          mask_q;
	logic [MAX_UNITS-1:0] cand_q;
	logic                 done_q;
	logic [2:0]           status_q;
	logic [5:0]           chosen_q;

	// client holdings, one row per client
	logic [MAX_UNITS-1:0] hold_q [MAX_CLIENTS];
	logic                 cl_ok;
	logic [CLW-1:0]       cl_idx;
	logic [MAX_UNITS-1:0] row;
	logic [63:0]          row64;
	logic                 in_rng;
	logic                 held;

	// cell row wiring, position 0 is the chain input
	logic                  tok  [MAX_UNITS+1];
	logic                  fnd  [MAX_UNITS+1];
	logic [USAGE_BITS-1:0] usev [MAX_UNITS+1];
	logic [UW-1:0]         idxv [MAX_UNITS+1];
	logic [6:0]            cntv [MAX_UNITS+1];
	logic [REF_BITS-1:0]   refv [MAX_UNITS];
	logic                  exv  [MAX_UNITS];
	logic [REF_BITS-1:0]   ref_sel;
	logic                  ex_sel;
	logic [63:0]          upper;

	unit_cmd_t cmd;
	logic      res_v;
	logic [2:0] res_st;
	logic [5:0] res_ch;
	logic       row_set, row_clr, row_zero;

	assign accept = start && !busy;
	assign busy   = (state_q == FSM_SCAN);
	assign eff    = (active_q > 7'(MAX_UNITS)) ? 7'(MAX_UNITS) : active_q;

	assign cl_ok  = (32'(req.client_id) < MAX_CLIENTS);
	assign cl_idx = CLW'(req.client_id);
	assign row    = cl_ok ? hold_q[cl_idx] : '0;
	assign row64  = 64'(row);
	assign in_rng = ({1'b0, req.unit_index} < eff);
	assign held   = row64[req.unit_index];
	assign ref_sel = refv[UW'(req.unit_index)];
	assign ex_sel  = exv[UW'(req.unit_index)];

	// mask bits above the cell row still count against active_units
	assign upper = mask_q >> MAX_UNITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, per-unit command and result
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.idx  = req.unit_index;
		res_v    = 1'b0;
		res_st   = ST_OK;
		res_ch   = '0;
		row_set  = 1'b0;
		row_clr  = 1'b0;
		row_zero = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					unique case (req.req_type)
						REQ_RESERVE: begin
							res_v = 1'b1;
							if (!in_rng || !cl_ok) begin
								res_st = ST_NO_UNIT;
							end else if (held) begin
								res_st = ST_ADDED;
							end else if (ex_sel) begin
								res_st = ST_EXCL;
							end else if (req.exclusive && ref_sel != '0) begin
								res_st = ST_SHARED;
							end else begin
								row_set      = 1'b1;
								cmd.rsv      = 1'b1;
								cmd.rsv_excl = req.exclusive;
							end
						end
						REQ_RELEASE: begin
							res_v = 1'b1;
							if (!in_rng) begin
								res_st = ST_NO_UNIT;
							end else if (!cl_ok || !held) begin
								res_st = ST_NOT_RES;
							end else begin
								row_clr = 1'b1;
								cmd.rel = 1'b1;
							end
						end
						REQ_OPEN: begin
							res_v    = 1'b1;
							row_zero = cl_ok;
						end
						REQ_DISPATCH: begin
							state_d = FSM_SCAN;
						end
						default: ;
					endcase
				end
			end
			FSM_SCAN: begin
				if (tok[MAX_UNITS]) begin
					state_d = FSM_IDLE;
					res_v   = 1'b1;
					if (cntv[MAX_UNITS] > eff) begin
						res_st = ST_WIDE;
					end else if (!fnd[MAX_UNITS]) begin
						res_st = ST_NONE;
					end else begin
						res_ch      = 6'(idxv[MAX_UNITS]);
						cmd.idx     = 6'(idxv[MAX_UNITS]);
						cmd.use_inc = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < MAX_CLIENTS; c++) begin
				hold_q[c] <= '0;
			end
		end else if (row_set) begin
			hold_q[cl_idx][UW'(req.unit_index)] <= 1'b1;
		end else if (row_clr) begin
			hold_q[cl_idx][UW'(req.unit_index)] <= 1'b0;
		end else if (row_zero) begin
			hold_q[cl_idx] <= '0;
		end
	end

	// dispatch operands held for the whole scan
	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q <= req.unit_mask;
			cand_q <= req.unit_mask[MAX_UNITS-1:0] & row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			launch_q <= accept && (req.req_type == REQ_DISPATCH);
			done_q   <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= res_st;
		chosen_q <= res_ch;
	end

	// chain input: token, empty minimum, count of mask bits beyond the row
	assign tok[0]  = launch_q;
	assign fnd[0]  = 1'b0;
	assign usev[0] = '0;
	assign idxv[0] = '0;
	assign cntv[0] = 7'($countones(upper));

	for (genvar i = 0; i < MAX_UNITS; i++) begin : g_cell
		urlud_cell #(
			.INDEX      (i),
			.UW         (UW),
			.USAGE_BITS (USAGE_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.cand    (cand_q[i]),
			.mbit    (mask_q[i]),
			.tok_in  (tok[i]),
			.fnd_in  (fnd[i]),
			.use_in  (usev[i]),
			.idx_in  (idxv[i]),
			.cnt_in  (cntv[i]),
			.tok_out (tok[i+1]),
			.fnd_out (fnd[i+1]),
			.use_out (usev[i+1]),
			.idx_out (idxv[i+1]),
			.cnt_out (cntv[i+1]),
			.refcnt  (refv[i]),
			.excl    (exv[i])
		);
	end

	assign done               = done_q;
	assign result.status      = status_q;
	assign result.chosen_unit = chosen_q;

	// a dispatch beat always enters the scan
	a_dispatch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.req_type == REQ_DISPATCH |=> busy)
		else $error("dispatch did not start a scan");

	// the token leaving the row ends the scan and strobes a result
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		busy && tok[MAX_UNITS] |=> !busy && done)
		else $error("scan end without result");

	// refused beats report no unit
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.chosen_unit == '0)
		else $error("refused result carries a unit");

	// only one token in flight during a scan
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		launch_q |-> !busy || !tok[MAX_UNITS])
		else $error("second scan token launched");

endmodule
`default_nettype wire
